[rtl/sobel_gradient_mag_angle_assert.svh]
// assertion macros used by the checker file
`ifndef SOBEL_GRADIENT_MAG_ANGLE_ASSERT_SVH
`define SOBEL_GRADIENT_MAG_ANGLE_ASSERT_SVH

// same-cycle implication
`define SGM_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("sgm check failed");

// next-cycle implication
`define SGM_ASSERT_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("sgm check failed");

`endif

[rtl/sgm_pkg.sv]
// shared constants, types and tables of the sobel gradient block
`default_nettype none
package sgm_pkg;
    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 16;
    localparam int GRAD_W  = 11;
    localparam int MAG_W   = 15;
    localparam int ANG_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int IMGW_W  = 12;

    localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IMGW_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [ROW_W-1:0]  RST_IMAGE_HEIGHT = 16'd480;

    // cordic datapath
    localparam int XW   = 24;
    localparam int ACCW = 25;
    localparam logic signed [ACCW-1:0] ATAN_PI = 25'sd3294199;
    localparam logic signed [ANG_W-1:0] ANG_LIM = 16'sd25736;

    // result kinds of one pixel
    localparam logic [1:0] K_NORM      = 2'd0;
    localparam logic [1:0] K_FIN       = 2'd1;
    localparam logic [1:0] K_LAST_NORM = 2'd2;
    localparam logic [1:0] K_LAST_FIN  = 2'd3;

    typedef struct packed {
        logic accept;
        logic upd;
        logic load;
        logic sq;
        logic iter;
        logic fin;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic pend_any;
        logic iter_last;
    } t_stat;

    // atan(2^-i) in units of 2^-20 rad
    function automatic logic signed [ACCW-1:0] sgm_atan(input logic [4:0] i);
        logic signed [ACCW-1:0] v;
        case (i)
            5'd0:    v = 25'sd823550;
            5'd1:    v = 25'sd486170;
            5'd2:    v = 25'sd256879;
            5'd3:    v = 25'sd130396;
            5'd4:    v = 25'sd65451;
            5'd5:    v = 25'sd32757;
            5'd6:    v = 25'sd16383;
            5'd7:    v = 25'sd8192;
            5'd8:    v = 25'sd4096;
            5'd9:    v = 25'sd2048;
            5'd10:   v = 25'sd1024;
            5'd11:   v = 25'sd512;
            5'd12:   v = 25'sd256;
            5'd13:   v = 25'sd128;
            5'd14:   v = 25'sd64;
            5'd15:   v = 25'sd32;
            5'd16:   v = 25'sd16;
            5'd17:   v = 25'sd8;
            5'd18:   v = 25'sd4;
            5'd19:   v = 25'sd2;
            5'd20:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

[rtl/sgm_pix_if.sv]
// pixel stream channel
`default_nettype none
interface sgm_pix_if;
    import sgm_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface
`default_nettype wire

[rtl/sgm_res_if.sv]
// gradient result channel
`default_nettype none
interface sgm_res_if;
    import sgm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [MAG_W-1:0]         magnitude;
    logic signed [ANG_W-1:0]  angle;
    logic                     last;
    modport source (output valid, output col, output row, output grad_x, output grad_y,
                    output magnitude, output angle, output last, input ready);
    modport sink (input valid, input col, input row, input grad_x, input grad_y,
                  input magnitude, input angle, input last, output ready);
endinterface
`default_nettype wire

[rtl/sobel_gradient_mag_angle.sv]
// top level of the streaming sobel gradient, magnitude and direction block
//
//  channel   dir  handshake          payload
//  i_pix     in   valid/ready        pixel
//  o_res     out  valid/ready        col, row, grad_x, grad_y, magnitude, angle, last
//  i_cfg_*   in   write enable only  index, data
//
// a pixel passes accept, line store update and pending result check; each result
// it releases then passes load, setup, iteration, finish and output wait,
// all on the one shared sqrt/cordic unit that iterates one step a cycle
// up to four results per pixel
// synchronous reset, no clearing pass: each frame writes a line before reading it
// a stalled result holds the whole block; no pixel is taken until all are delivered
`default_nettype none
module sobel_gradient_mag_angle #(
    parameter int MAX_WIDTH     = sgm_pkg::DEF_MAX_WIDTH,
    parameter int CORDIC_STAGES = sgm_pkg::DEF_CORDIC_STAGES
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    sgm_pix_if.sink                    i_pix,
    sgm_res_if.source                  o_res,
    input  wire                        i_cfg_we,
    input  wire [sgm_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  wire [sgm_pkg::CFG_W-1:0]   i_cfg_data
);
    import sgm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sgm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_pix.valid), .i_out_ready(o_res.ready),
        .i_stat(stat), .o_cmd(cmd),
        .o_in_ready(i_pix.ready), .o_out_valid(o_res.valid)
    );

    sgm_dp #(.MAX_WIDTH(MAX_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pixel(i_pix.pixel),
        .o_col(o_res.col), .o_row(o_res.row),
        .o_grad_x(o_res.grad_x), .o_grad_y(o_res.grad_y),
        .o_magnitude(o_res.magnitude), .o_angle(o_res.angle), .o_last(o_res.last)
    );
endmodule
`default_nettype wire

[rtl/sgm_ram.sv]
// generic single-write, single-read ram with registered read
`default_nettype none
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/sgm_ctrl.sv]
// controller state machine of the sobel gradient block
`default_nettype none
module sgm_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_out_ready,
    input  sgm_pkg::t_stat i_stat,
    output sgm_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);
    import sgm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_ITER = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        o_cmd.accept = o_in_ready && i_in_valid;
        o_cmd.upd    = (r_state == S_UPD);
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.sq     = (r_state == S_SQ);
        o_cmd.iter   = (r_state == S_ITER);
        o_cmd.fin    = (r_state == S_FIN);
        o_cmd.take   = o_out_valid && i_out_ready;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPD;
            end
            S_UPD:  n_state = S_LOAD;
            S_LOAD: begin
                n_state = i_stat.pend_any ? S_SQ : S_IDLE;
            end
            S_SQ:   n_state = S_ITER;
            S_ITER: begin
                if (i_stat.iter_last) n_state = S_FIN;
            end
            S_FIN:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_LOAD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

[rtl/sgm_dp.sv]
// datapath: line stores, window, gradients, shared sqrt and cordic unit
`default_nettype none
module sgm_dp #(
    parameter int MAX_WIDTH     = sgm_pkg::DEF_MAX_WIDTH,
    parameter int CORDIC_STAGES = sgm_pkg::DEF_CORDIC_STAGES
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  sgm_pkg::t_cmd                     i_cmd,
    output sgm_pkg::t_stat                    o_stat,
    input  wire                               i_cfg_we,
    input  wire [sgm_pkg::CIDX_W-1:0]         i_cfg_idx,
    input  wire [sgm_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire [sgm_pkg::PIX_W-1:0]          i_pixel,
    output logic [sgm_pkg::COL_W-1:0]         o_col,
    output logic [sgm_pkg::ROW_W-1:0]         o_row,
    output logic signed [sgm_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [sgm_pkg::GRAD_W-1:0] o_grad_y,
    output logic [sgm_pkg::MAG_W-1:0]         o_magnitude,
    output logic signed [sgm_pkg::ANG_W-1:0]  o_angle,
    output logic                              o_last
);
    import sgm_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int ITER = (CORDIC_STAGES > 16) ? CORDIC_STAGES : 16;
    localparam int SW   = $clog2(ITER);
    localparam logic [CW:0] MAXW = (CW+1)'(MAX_WIDTH);

    // configuration and counters
    logic [IMGW_W-1:0] r_img_w;
    logic [ROW_W-1:0]  r_img_h;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CW:0]       ew;
    logic [ROW_W-1:0]  eh;
    logic              is_fin, is_lastrow;

    always_comb begin
        if (r_img_w < IMGW_W'(2)) ew = (CW+1)'(2);
        else if (32'(r_img_w) > 32'(MAX_WIDTH)) ew = MAXW;
        else ew = (CW+1)'(r_img_w);
        eh = (r_img_h < ROW_W'(2)) ? ROW_W'(2) : r_img_h;
        is_fin     = ({1'b0, r_col} == ew - (CW+1)'(1));
        is_lastrow = (r_row == eh - ROW_W'(1));
    end

    // line stores
    logic [PIX_W-1:0] r_pix, a_rd, b_rd, mid, up;

    assign mid = (r_row != '0) ? a_rd : '0;
    assign up  = (r_row >= ROW_W'(2)) ? b_rd : r_pix;

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
        .i_clk(i_clk), .i_we(i_cmd.upd), .i_waddr(r_col), .i_wdata(r_pix),
        .i_raddr(r_col), .o_rdata(a_rd)
    );
    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
        .i_clk(i_clk), .i_we(i_cmd.upd && (r_row != '0)), .i_waddr(r_col), .i_wdata(mid),
        .i_raddr(r_col), .o_rdata(b_rd)
    );

    // window: three columns of (up, mid, down)
    logic [PIX_W-1:0] r_win [9];
    logic [3:0]       r_pend;
    logic [CW-1:0]    r_pc;
    logic [ROW_W-1:0] r_pr;
    logic [1:0]       r_kind, sel;

    always_comb begin
        sel = K_LAST_FIN;
        if (r_pend[0]) sel = K_NORM;
        else if (r_pend[1]) sel = K_FIN;
        else if (r_pend[2]) sel = K_LAST_NORM;
    end

    assign o_stat.pend_any = (r_pend != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_IMAGE_WIDTH;
            r_img_h <= RST_IMAGE_HEIGHT;
            r_col   <= '0;
            r_row   <= '0;
            r_pend  <= '0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_IMAGE_WIDTH || i_cfg_idx == CFG_IMAGE_HEIGHT)) begin
                if (i_cfg_idx == CFG_IMAGE_WIDTH) r_img_w <= i_cfg_data[IMGW_W-1:0];
                else r_img_h <= i_cfg_data;
                r_col <= '0;
                r_row <= '0;
            end else if (i_cmd.upd) begin
                if (is_fin) begin
                    r_col <= '0;
                    r_row <= is_lastrow ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.upd) begin
                for (int k = 0; k < 6; k++) r_win[k] <= r_win[k+3];
                r_win[6] <= up;
                r_win[7] <= mid;
                r_win[8] <= r_pix;
                r_pend[0] <= (r_row != '0) && (r_col != '0);
                r_pend[1] <= (r_row != '0) && (r_col != '0) && is_fin;
                r_pend[2] <= (r_row != '0) && (r_col != '0) && is_lastrow;
                r_pend[3] <= (r_row != '0) && (r_col != '0) && is_fin && is_lastrow;
            end else if (i_cmd.take) begin
                r_pend[r_kind] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_pix <= i_pixel;
        if (i_cmd.upd) begin
            r_pc <= r_col;
            r_pr <= r_row;
        end
    end

    // triple selection and gradients
    logic [PIX_W-1:0]  t [9];
    logic [PIX_W-1:0]  lt [3], mt [3], rt [3];
    logic signed [11:0] gx, gy;
    logic [CW-1:0]     ocol;
    logic [ROW_W-1:0]  orow;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (sel[1]) begin
                t[k*3+0] = r_win[k*3+1];
                t[k*3+1] = r_win[k*3+2];
                t[k*3+2] = r_win[k*3+1];
            end else begin
                t[k*3+0] = r_win[k*3+0];
                t[k*3+1] = r_win[k*3+1];
                t[k*3+2] = r_win[k*3+2];
            end
        end
        for (int j = 0; j < 3; j++) begin
            if (sel[0]) begin
                // right edge mirrors column w-2
                lt[j] = t[3+j]; mt[j] = t[6+j]; rt[j] = t[3+j];
            end else if (r_pc == CW'(1)) begin
                // left edge mirrors column 1
                lt[j] = t[6+j]; mt[j] = t[3+j]; rt[j] = t[6+j];
            end else begin
                lt[j] = t[j]; mt[j] = t[3+j]; rt[j] = t[6+j];
            end
        end
        gx = (12'(rt[0]) - 12'(lt[0])) + ((12'(rt[1]) - 12'(lt[1])) <<< 1)
           + (12'(rt[2]) - 12'(lt[2]));
        gy = (12'(lt[2]) - 12'(lt[0])) + ((12'(mt[2]) - 12'(mt[0])) <<< 1)
           + (12'(rt[2]) - 12'(rt[0]));
        ocol = sel[0] ? ew[CW-1:0] - CW'(1) : ((r_pc == CW'(1)) ? '0 : r_pc - CW'(1));
        orow = sel[1] ? r_pr : r_pr - ROW_W'(1);
    end

    // shared magnitude (bit-pair sqrt) and angle (cordic) unit
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [30:0]              r_rem, r_res, r_bit;
    logic signed [XW-1:0]     r_x, r_y, x_sh, y_sh;
    logic signed [ACCW-1:0]   r_acc, acc_r;
    logic [SW-1:0]            r_step;
    logic signed [2*GRAD_W-1:0] sq_x, sq_y;
    logic [30:0]              n_val, rb;
    logic [MAG_W-1:0]         mag;
    logic signed [ACCW-1:0]   q;

    assign o_stat.iter_last = (r_step == SW'(ITER-1));

    always_comb begin
        sq_x  = r_gx * r_gx;
        sq_y  = r_gy * r_gy;
        n_val = 31'(sq_x + sq_y) << 8;
        x_sh  = r_x >>> r_step;
        y_sh  = r_y >>> r_step;
        rb    = r_res + r_bit;
        mag   = (r_rem > r_res) ? MAG_W'(r_res + 31'd1) : MAG_W'(r_res);
        // round half away from zero at bit 7
        if (!r_acc[ACCW-1]) acc_r = (r_acc + ACCW'(64)) >>> 7;
        else acc_r = -((-r_acc + ACCW'(64)) >>> 7);
        q = acc_r;
        if (q > ACCW'(ANG_LIM)) q = ACCW'(ANG_LIM);
        if (q < -ACCW'(ANG_LIM)) q = -ACCW'(ANG_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= sel;
            r_gx     <= gx[GRAD_W-1:0];
            r_gy     <= gy[GRAD_W-1:0];
            o_grad_x <= gx[GRAD_W-1:0];
            o_grad_y <= gy[GRAD_W-1:0];
            o_col    <= COL_W'(32'(ocol));
            o_row    <= orow;
            o_last   <= (sel == K_LAST_FIN);
        end
        if (i_cmd.sq) begin
            r_rem  <= n_val;
            r_res  <= '0;
            r_bit  <= 31'h4000_0000;
            r_step <= '0;
            if (r_gx[GRAD_W-1]) begin
                r_x   <= -(XW'(r_gx) <<< 8);
                r_y   <= -(XW'(r_gy) <<< 8);
                r_acc <= r_gy[GRAD_W-1] ? -ATAN_PI : ATAN_PI;
            end else begin
                r_x   <= XW'(r_gx) <<< 8;
                r_y   <= XW'(r_gy) <<< 8;
                r_acc <= '0;
            end
        end
        if (i_cmd.iter) begin
            r_step <= r_step + SW'(1);
            if (r_bit != '0) begin
                if (r_rem >= rb) begin
                    r_rem <= r_rem - rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            if (32'(r_step) < CORDIC_STAGES) begin
                if (r_y > 0) begin
                    r_x   <= r_x + y_sh;
                    r_y   <= r_y - x_sh;
                    r_acc <= r_acc + sgm_atan(5'(r_step));
                end else if (r_y < 0) begin
                    r_x   <= r_x - y_sh;
                    r_y   <= r_y + x_sh;
                    r_acc <= r_acc - sgm_atan(5'(r_step));
                end
            end
        end
        if (i_cmd.fin) begin
            o_magnitude <= mag;
            o_angle     <= q[ANG_W-1:0];
        end
    end
endmodule
`default_nettype wire

[rtl/sgm_checker.sv]
// port-level checks of the sobel gradient block and their binding
`default_nettype none
`include "sobel_gradient_mag_angle_assert.svh"
module sgm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [47:0] i_out_data
);
    // one item at a time: no request taken while a result is shown
    `SGM_ASSERT_IMP(a_excl, i_clk, !i_rst_n, i_out_valid, !i_in_ready)
    // an accepted pixel is always followed by a line store update that takes no pixel
    `SGM_ASSERT_NXT(a_busy, i_clk, !i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // reset leaves no result pending
    `SGM_ASSERT_NXT(a_rst, i_clk, 1'b0, !i_rst_n, !i_out_valid)
    // a stalled result keeps its magnitude, angle, column and low grad_x bits
    `SGM_ASSERT_NXT(a_hold, i_clk, !i_rst_n, i_out_valid && !i_out_ready,
                    i_out_valid && $stable(i_out_data))
endmodule

bind sobel_gradient_mag_angle sgm_checker u_sgm_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_pix.valid),
    .i_in_ready(i_pix.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_out_data({o_res.magnitude, o_res.angle, o_res.col, o_res.grad_x[5:0]})
);
`default_nettype wire

[dv/testbench.sv]
// self-checking testbench of the streaming sobel gradient, magnitude and direction block
`timescale 1ns / 100ps
module testbench;
    import sgm_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [MAG_W-1:0]         magnitude;
        logic signed [ANG_W-1:0]  angle;
        logic                     last;
    } grad_res_t;

    class grad_scoreboard;
        byte unsigned prev_row[2048];
        byte unsigned prev2_row[2048];
        byte unsigned win[9];
        int unsigned  col_pos, row_pos, img_w, img_h;
        grad_res_t    expected_q[$];
        int           errors, checked;
        int           atan_lut[16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                       8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

        function new();
            foreach (prev_row[i]) begin
                prev_row[i] = 0;
                prev2_row[i] = 0;
            end
            foreach (win[i]) win[i] = 0;
            col_pos = 0;
            row_pos = 0;
            img_w = 640;
            img_h = 480;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_IMAGE_WIDTH) img_w = 32'(data[IMGW_W-1:0]);
            else if (idx == CFG_IMAGE_HEIGHT) img_h = 32'(data);
            else return;
            col_pos = 0;
            row_pos = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic signed [ANG_W-1:0] direction(int gx, int gy);
            longint x, y, acc, nx, q;
            x = gx * 256;
            y = gy * 256;
            acc = 0;
            if (gx < 0) begin
                acc = (gy >= 0) ? 3294199 : -3294199;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 16; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    x = nx;
                    acc += atan_lut[i];
                end else if (y < 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    x = nx;
                    acc -= atan_lut[i];
                end
            end
            q = (acc >= 0) ? ((acc + 64) >>> 7) : -(((-acc) + 64) >>> 7);
            if (q > 25736) q = 25736;
            if (q < -25736) q = -25736;
            return q[ANG_W-1:0];
        endfunction

        // t holds (up, mid, down) triples; li, mi, ri select left, centre, right
        function void push_result(int c, int r, byte unsigned t[9], int li, int mi, int ri,
                                  bit fin);
            int gx, gy;
            longint n, lo, hi, md;
            grad_res_t e;
            gx = (int'(t[ri]) - t[li]) + 2 * (int'(t[ri+1]) - t[li+1])
                + (int'(t[ri+2]) - t[li+2]);
            gy = (int'(t[li+2]) - t[li]) + 2 * (int'(t[mi+2]) - t[mi])
                + (int'(t[ri+2]) - t[ri]);
            n = longint'(gx * gx + gy * gy) * 256;
            lo = 0;
            hi = 65536;
            while (hi - lo > 1) begin
                md = (lo + hi) / 2;
                if (md * md <= n) lo = md;
                else hi = md;
            end
            if (n - lo * lo > lo) lo++;
            e.col = COL_W'(c);
            e.row = ROW_W'(r);
            e.grad_x = GRAD_W'(gx);
            e.grad_y = GRAD_W'(gy);
            e.magnitude = MAG_W'(lo);
            e.angle = direction(gx, gy);
            e.last = fin;
            expected_q.push_back(e);
        endfunction

        function void note_pixel(byte unsigned p);
            int unsigned w, h, c, r;
            byte unsigned up, mid;
            byte unsigned lr[9];
            bit fin, lastrow;
            w = img_w;
            h = img_h;
            if (w < 2) w = 2;
            if (w > 2048) w = 2048;
            if (h < 2) h = 2;
            c = (col_pos >= w) ? 0 : col_pos;
            r = (row_pos >= h) ? 0 : row_pos;
            mid = (r >= 1) ? prev_row[c] : 0;
            up = (r >= 2) ? prev2_row[c] : p;
            if (r >= 1) prev2_row[c] = mid;
            prev_row[c] = p;
            for (int k = 0; k < 6; k++) win[k] = win[k+3];
            win[6] = up;
            win[7] = mid;
            win[8] = p;
            if (r >= 1 && c >= 1) begin
                fin = (c == w - 1);
                lastrow = (r == h - 1);
                if (c == 1) push_result(0, r - 1, win, 6, 3, 6, 0);
                else push_result(c - 1, r - 1, win, 0, 3, 6, 0);
                if (fin) push_result(w - 1, r - 1, win, 3, 6, 3, 0);
                if (lastrow) begin
                    // bottom border reflects the row above
                    for (int k = 0; k < 3; k++) begin
                        lr[k*3]   = win[k*3+1];
                        lr[k*3+1] = win[k*3+2];
                        lr[k*3+2] = win[k*3+1];
                    end
                    if (c == 1) push_result(0, r, lr, 6, 3, 6, 0);
                    else push_result(c - 1, r, lr, 0, 3, 6, 0);
                    if (fin) push_result(w - 1, r, lr, 3, 6, 3, 1);
                end
            end
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void check_result(grad_res_t a);
            grad_res_t e;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: actual %p", $realtime, a);
                return;
            end
            e = expected_q.pop_front();
            if (e !== a) begin
                errors++;
                $display("%0t result mismatch: expected %p actual %p", $realtime, e, a);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    sgm_pix_if pix ();
    sgm_res_if res ();

    sobel_gradient_mag_angle u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    grad_scoreboard sb = new();
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int pixels_sent = 0;
    int frames_run = 0;

    initial begin
        pix.valid = 1'b0;
        pix.pixel = '0;
        res.ready = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side stalls, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= !(gaps_on && $urandom_range(99) < 13);
        end
    end

    // check at the falling edge, where the request of the coming edge is stable
    always @(negedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.check_result('{res.col, res.row, res.grad_x, res.grad_y, res.magnitude,
                              res.angle, res.last});
        if (!i_rst_n || (res.valid && res.ready) || (pix.valid && pix.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t timeout, %0d results still expected", $realtime, sb.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_pixel(input byte unsigned p);
        bit taken;
        while (gaps_on && $urandom_range(99) < 13) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= p;
        do begin
            @(negedge i_clk);
            taken = pix.ready;
            @(posedge i_clk);
        end while (!taken);
        sb.note_pixel(p);
        pixels_sent++;
    endtask

    // sender pauses until all results are out, then past the block's latency
    task automatic drain();
        pix.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h);
        drain();
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
        frames_run++;
    endtask

    function automatic byte unsigned any_pixel();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int w, h, n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, full-scale steps
        set_frame(2, 2);
        send_pixel(0); send_pixel(255); send_pixel(255); send_pixel(0);
        // horizontal ramp up and down, vertical ramp: largest and pure-axis gradients
        set_frame(3, 3);
        for (int i = 0; i < 9; i++) send_pixel((i % 3) == 2 ? 255 : 0);
        for (int i = 0; i < 9; i++) send_pixel((i % 3) == 0 ? 255 : 0);
        for (int i = 0; i < 9; i++) send_pixel(i >= 6 ? 255 : i >= 3 ? 128 : 0);

        // clamped register values: width and height below two
        drain();
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(0));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(1));
        for (int i = 0; i < 4; i++) send_pixel(any_pixel());
        // tallest frame, left unfinished
        set_frame(2, 16'hFFFF);
        for (int i = 0; i < 9; i++) send_pixel(any_pixel());
        // writes to unused indexes leave the frame running
        set_frame(3, 3);
        for (int i = 0; i < 4; i++) send_pixel(any_pixel());
        drain();
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'h0000);
        for (int i = 0; i < 5; i++) send_pixel(any_pixel());
        // widths above the clamp, left unfinished
        set_frame(16'h0FFF, 2);
        for (int i = 0; i < 6; i++) send_pixel(any_pixel());
        set_frame(16'hFFFF, 2);
        for (int i = 0; i < 6; i++) send_pixel(any_pixel());

        // random frames, a few cut short
        n = 0;
        while (n < 300) begin
            w = ($urandom_range(3) == 0) ? 2 : $urandom_range(2, 10);
            h = ($urandom_range(3) == 0) ? 2 : $urandom_range(2, 6);
            set_frame(w, h);
            gaps_on = !(frames_run % 7 == 3);
            if (frames_run % 9 == 4) hold_req = 1'b1;
            if ($urandom_range(9) == 0) h = $urandom_range(1, h);
            for (int i = 0; i < w * h; i++) begin
                send_pixel(any_pixel());
                if ($urandom_range(49) == 0) drain();
            end
            n += w * h;
        end
        gaps_on = 1'b1;

        drain();
        $display("covered %0d frame settings, %0d pixels, %0d gradient results", frames_run,
                 pixels_sent, sb.checked);
        $display("including clamped sizes, unused indexes, borders and long result stalls");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
